>>> rtl/snbs_pkg.sv
// snbs_pkg: shared types and constants for the nearest sphere-of-influence search
// no dependencies; imported by the engine, the top level and the checker
`timescale 1ns / 1ps

package snbs_pkg;

  // input item codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // link word layout: parent slot in the low nibble, then has-parent, then star
  localparam int LINK_HASP = 4;
  localparam int LINK_STAR = 5;
  localparam int LINK_W    = 6;

  // big-number engine operations
  typedef enum logic [1:0] {
    MAC_CLEAR = 2'd0,  // accumulator to zero
    MAC_LOADX = 2'd1,  // load operand, optionally clear accumulator
    MAC_MOVE  = 2'd2,  // operand takes accumulator, accumulator cleared
    MAC_PASS  = 2'd3   // accumulator += operand * word, shifted by limbs
  } mac_op_e;

  typedef struct packed {
    mac_op_e     op;
    logic        clr;
    logic [63:0] val;
    logic [31:0] w;
    logic [7:0]  j;
  } mac_cmd_t;

endpackage

>>> rtl/snbs_if.sv
// snbs_if: valid/ready channels for input items, result items and configuration
// depends on nothing; used by the top level ports
`timescale 1ns / 1ps

interface snbs_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [3:0]         entry_slot;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [31:0]        orbit_axis;
  logic [31:0]        body_mass_in;
  logic [3:0]         parent_slot;
  logic               has_parent;
  logic               star_flag;

  modport source (
    output valid, action, entry_slot, pos_x, pos_y, pos_z, orbit_axis, body_mass_in,
           parent_slot, has_parent, star_flag,
    input  ready
  );
  modport sink (
    input  valid, action, entry_slot, pos_x, pos_y, pos_z, orbit_axis, body_mass_in,
           parent_slot, has_parent, star_flag,
    output ready
  );
endinterface

interface snbs_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [3:0] nearest_body;

  modport source (output valid, found, nearest_body, input ready);
  modport sink (input valid, found, nearest_body, output ready);
endinterface

interface snbs_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] active_bodies;

  modport source (output valid, active_bodies, input ready);
  modport sink (input valid, active_bodies, output ready);
endinterface

>>> rtl/snbs_ram.sv
// snbs_ram: generic single-write, single-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module snbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/snbs_mac.sv
// snbs_mac: limb-serial big-number multiply-accumulate engine, one 32x32 product a cycle
// depends on snbs_pkg for the command type
`timescale 1ns / 1ps

module snbs_mac import snbs_pkg::*; #(
  parameter int LIMBS = 15
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  mac_cmd_t              cmd_i,
  output logic                  done_o,
  output logic [LIMBS*32-1:0]   x_flat_o
);

  localparam int LW = $clog2(LIMBS);

  logic [31:0]   r_q [LIMBS];
  logic [31:0]   x_q [LIMBS];
  logic          busy_q;
  logic          done_q;
  logic [LW-1:0] i_q;
  logic [LW-1:0] j_q;
  logic [31:0]   w_q;
  logic [31:0]   carry_q;

  logic [31:0]   xi;
  logic [63:0]   prod;
  logic [63:0]   sum;

  // one limb of operand times word plus accumulator limb and carry
  always_comb begin
    xi   = (i_q >= j_q) ? x_q[i_q - j_q] : 32'd0;
    prod = 64'(xi) * 64'(w_q);
    sum  = prod + 64'(r_q[i_q]) + 64'(carry_q);
  end

  // sequencing of a pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      if (start_i) begin
        if (cmd_i.op == MAC_PASS) begin
          busy_q <= 1'b1;
          i_q    <= '0;
          done_q <= 1'b0;
        end else begin
          done_q <= 1'b1;
        end
      end else if (busy_q) begin
        if (i_q == LW'(LIMBS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          i_q    <= i_q + 1'b1;
          done_q <= 1'b0;
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  // limb registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      case (cmd_i.op)
        MAC_CLEAR: begin
          for (int k = 0; k < LIMBS; k++) r_q[k] <= 32'd0;
        end
        MAC_LOADX: begin
          for (int k = 0; k < LIMBS; k++) begin
            if (k == 0) begin
              x_q[k] <= cmd_i.val[31:0];
            end else if (k == 1) begin
              x_q[k] <= cmd_i.val[63:32];
            end else begin
              x_q[k] <= 32'd0;
            end
            if (cmd_i.clr) begin
              r_q[k] <= 32'd0;
            end
          end
        end
        MAC_MOVE: begin
          for (int k = 0; k < LIMBS; k++) begin
            x_q[k] <= r_q[k];
            r_q[k] <= 32'd0;
          end
        end
        MAC_PASS: begin
          j_q     <= cmd_i.j[LW-1:0];
          w_q     <= cmd_i.w;
          carry_q <= 32'd0;
        end
        default: begin
        end
      endcase
    end else if (busy_q) begin
      r_q[i_q] <= sum[31:0];
      carry_q  <= sum[63:32];
    end
  end

  // operand as one flat word
  always_comb begin
    for (int k = 0; k < LIMBS; k++) x_flat_o[k*32 +: 32] = x_q[k];
  end

  assign done_o = done_q;

endmodule

>>> rtl/soi_nearest_body_search.sv
// a write only stores into the table; a query walks slots from the top down, about 40 engine
// passes per live body, while a skipped body runs no pass; up to 16 bodies are searched, and
// all products come from the one 32x32 multiplier
// throughput: one item at a time; a finished result waits in the output register
// reset: control and active_bodies cleared; table memories hold nothing until written
`timescale 1ns / 1ps

module soi_nearest_body_search import snbs_pkg::*; #(
  parameter int MAX_BODIES = 16,
  parameter int COORD_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  snbs_in_if.sink   in_i,
  snbs_cfg_if.sink  cfg_i,
  snbs_out_if.source out_o
);

  localparam int SW    = $clog2(MAX_BODIES);
  localparam int CW    = $clog2(MAX_BODIES + 1);
  localparam int CB    = COORD_BITS;
  localparam int XL    = (CB + 32) / 32;
  localparam int DB    = 2 * CB + 4;
  localparam int DL    = (DB + 31) / 32;
  localparam int LHSL  = (5 * DB + 128 + 31) / 32;
  localparam int LIMBS = (LHSL > 14) ? LHSL : 14;
  localparam int LJW   = (DL > 1) ? $clog2(DL) : 1;
  localparam int BW    = 3 * CB + 64 + LINK_W;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RD   = 9'b000000010,
    S_PAR  = 9'b000000100,
    S_CHK  = 9'b000001000,
    S_OP   = 9'b000010000,
    S_WAIT = 9'b000100000,
    S_CMP  = 9'b001000000,
    S_NEXT = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_e;

  typedef enum logic [10:0] {
    P_CLR   = 11'b00000000001,
    P_D2LD  = 11'b00000000010,
    P_D2MUL = 11'b00000000100,
    P_D2MV  = 11'b00000001000,
    P_LONE  = 11'b00000010000,
    P_LD    = 11'b00000100000,
    P_LM    = 11'b00001000000,
    P_RONE  = 11'b00010000000,
    P_RA    = 11'b00100000000,
    P_RM    = 11'b01000000000,
    P_IDLE  = 11'b10000000000
  } phase_e;

  state_e state_q, state_d;
  phase_e ph_q;

  logic [4:0]            active_q;
  logic [CW-1:0]         idx_q;
  logic [SW-1:0]         slot_q;
  logic [3:0]            rep_q;
  logic [LJW-1:0]        lj_q;
  logic                  mv_q;
  logic                  found_q;
  logic [SW-1:0]         best_q;
  logic                  out_valid_q;
  logic                  out_found_q;
  logic [3:0]            out_body_q;

  logic signed [CB-1:0]  qx_q, qy_q, qz_q;
  logic signed [CB-1:0]  bx_q, by_q, bz_q;
  logic [31:0]           axis_q, mass_q, pmass_q;
  logic [LINK_W-1:0]     link_q;
  logic                  par_ok_q;
  logic [CB:0]           dabs_q [3];
  logic [DL*32-1:0]      d_q;
  logic [DL*32-1:0]      best_d_q;
  logic [LIMBS*32-1:0]   lhs_q;

  // memories and engine wiring
  logic                  wr_en;
  logic [SW-1:0]         wr_addr;
  logic [BW-1:0]         b_wdata, b_rdata;
  logic [SW-1:0]         b_raddr, m_raddr;
  logic [31:0]           m_rdata;
  logic                  mac_start, mac_done;
  mac_cmd_t              mac_cmd;
  logic [LIMBS*32-1:0]   x_flat;

  logic                  in_xfer, out_xfer;
  logic [CW-1:0]         count;
  logic [CB:0]           dsel;
  logic [63:0]           dsel_sh;
  logic [DL*32-1:0]      d_sh;
  logic [CB:0]           dx_abs, dy_abs, dz_abs;
  logic                  skip;
  logic                  cand;
  logic [3:0]            b_parent;

  // handshakes
  assign in_i.ready  = (state_q == S_IDLE);
  assign in_xfer     = in_i.valid && in_i.ready;
  assign out_xfer    = out_valid_q && out_o.ready;
  assign cfg_i.ready = 1'b1;

  assign out_o.valid        = out_valid_q;
  assign out_o.found        = out_found_q;
  assign out_o.nearest_body = out_body_q;

  // table write on a write item inside the table
  assign wr_en   = in_xfer && (in_i.action == ACT_WRITE) && (32'(in_i.entry_slot) < MAX_BODIES);
  assign wr_addr = SW'(in_i.entry_slot);
  assign b_wdata = {in_i.star_flag, in_i.has_parent, in_i.parent_slot, in_i.body_mass_in,
                    in_i.orbit_axis, CB'(in_i.pos_z), CB'(in_i.pos_y), CB'(in_i.pos_x)};

  assign b_raddr  = SW'(idx_q - CW'(1));
  assign b_parent = b_rdata[3*CB+64 +: 4];
  assign m_raddr  = SW'(b_parent);

  snbs_ram #(.WIDTH(BW), .DEPTH(MAX_BODIES)) u_body_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (b_wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  snbs_ram #(.WIDTH(32), .DEPTH(MAX_BODIES)) u_mass_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (in_i.body_mass_in),
    .raddr_i (m_raddr),
    .rdata_o (m_rdata)
  );

  snbs_mac #(.LIMBS(LIMBS)) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mac_start),
    .cmd_i    (mac_cmd),
    .done_o   (mac_done),
    .x_flat_o (x_flat)
  );

  // saturated search count
  assign count = (32'(active_q) > MAX_BODIES) ? CW'(MAX_BODIES) : CW'(active_q);

  // absolute coordinate differences
  always_comb begin
    logic signed [CB:0] ex, ey, ez;
    ex = (CB+1)'(qx_q) - (CB+1)'(bx_q);
    ey = (CB+1)'(qy_q) - (CB+1)'(by_q);
    ez = (CB+1)'(qz_q) - (CB+1)'(bz_q);
    dx_abs = ex[CB] ? -ex : ex;
    dy_abs = ey[CB] ? -ey : ey;
    dz_abs = ez[CB] ? -ez : ez;
  end

  assign skip = link_q[LINK_STAR] || !link_q[LINK_HASP] || !par_ok_q ||
                (axis_q == 32'd0) || (mass_q == 32'd0) || (m_rdata == 32'd0);

  // operand word selection
  always_comb begin
    case (rep_q[1:0])
      2'd0:    dsel = dabs_q[0];
      2'd1:    dsel = dabs_q[1];
      default: dsel = dabs_q[2];
    endcase
    dsel_sh = 64'(dsel) >> {lj_q, 5'b0};
    d_sh    = d_q >> {lj_q, 5'b0};
  end

  // engine command from the current phase
  always_comb begin
    mac_cmd     = '0;
    mac_cmd.op  = MAC_CLEAR;
    case (ph_q)
      P_CLR: mac_cmd.op = MAC_CLEAR;
      P_D2LD: begin
        mac_cmd.op  = MAC_LOADX;
        mac_cmd.val = 64'(dsel);
      end
      P_D2MUL: begin
        mac_cmd.op = MAC_PASS;
        mac_cmd.w  = dsel_sh[31:0];
        mac_cmd.j  = 8'(lj_q);
      end
      P_D2MV: mac_cmd.op = MAC_MOVE;
      P_LONE, P_RONE: begin
        mac_cmd.op  = MAC_LOADX;
        mac_cmd.clr = 1'b1;
        mac_cmd.val = 64'd1;
      end
      P_LD: begin
        mac_cmd.op = mv_q ? MAC_MOVE : MAC_PASS;
        mac_cmd.w  = d_sh[31:0];
        mac_cmd.j  = 8'(lj_q);
      end
      P_LM: begin
        mac_cmd.op = mv_q ? MAC_MOVE : MAC_PASS;
        mac_cmd.w  = pmass_q;
      end
      P_RA: begin
        mac_cmd.op = mv_q ? MAC_MOVE : MAC_PASS;
        mac_cmd.w  = axis_q;
      end
      P_RM: begin
        mac_cmd.op = mv_q ? MAC_MOVE : MAC_PASS;
        mac_cmd.w  = mass_q;
      end
      default: mac_cmd.op = MAC_CLEAR;
    endcase
  end

  assign mac_start = (state_q == S_OP);
  assign cand      = (lhs_q <= x_flat) && (!found_q || (d_q < best_d_q));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer && (in_i.action == ACT_QUERY)) begin
          state_d = (count == '0) ? S_FIN : S_RD;
        end
      end
      S_RD:   state_d = S_PAR;
      S_PAR:  state_d = S_CHK;
      S_CHK:  state_d = skip ? S_NEXT : S_OP;
      S_OP:   state_d = S_WAIT;
      S_WAIT: begin
        if (mac_done) begin
          state_d = (ph_q == P_RM && mv_q && rep_q == 4'd3) ? S_CMP : S_OP;
        end
      end
      S_CMP:  state_d = S_NEXT;
      S_NEXT: state_d = (idx_q == CW'(1)) ? S_FIN : S_RD;
      S_FIN:  state_d = (!out_valid_q || out_o.ready) ? S_IDLE : S_FIN;
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ph_q        <= P_IDLE;
      active_q    <= 5'd0;
      idx_q       <= '0;
      rep_q       <= 4'd0;
      lj_q        <= '0;
      mv_q        <= 1'b0;
      found_q     <= 1'b0;
      best_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // configuration transfer
      if (cfg_i.valid) begin
        active_q <= cfg_i.active_bodies;
      end

      // query start
      if (state_q == S_IDLE && in_xfer && in_i.action == ACT_QUERY) begin
        idx_q   <= count;
        found_q <= 1'b0;
        best_q  <= '0;
      end

      if (state_q == S_CHK && !skip) begin
        ph_q <= P_CLR;
      end

      // phase walk on engine completion
      if (state_q == S_WAIT && mac_done) begin
        case (ph_q)
          P_CLR: begin
            ph_q  <= P_D2LD;
            rep_q <= 4'd0;
          end
          P_D2LD: begin
            ph_q <= P_D2MUL;
            lj_q <= '0;
          end
          P_D2MUL: begin
            if (lj_q == LJW'(XL - 1)) begin
              if (rep_q == 4'd2) begin
                ph_q <= P_D2MV;
              end else begin
                rep_q <= rep_q + 4'd1;
                ph_q  <= P_D2LD;
              end
            end else begin
              lj_q <= lj_q + 1'b1;
            end
          end
          P_D2MV: ph_q <= P_LONE;
          P_LONE: begin
            ph_q  <= P_LD;
            rep_q <= 4'd0;
            lj_q  <= '0;
            mv_q  <= 1'b0;
          end
          P_LD: begin
            if (mv_q) begin
              mv_q <= 1'b0;
              lj_q <= '0;
              if (rep_q == 4'd4) begin
                ph_q  <= P_LM;
                rep_q <= 4'd0;
              end else begin
                rep_q <= rep_q + 4'd1;
              end
            end else if (lj_q == LJW'(DL - 1)) begin
              mv_q <= 1'b1;
            end else begin
              lj_q <= lj_q + 1'b1;
            end
          end
          P_LM: begin
            if (mv_q) begin
              mv_q <= 1'b0;
              if (rep_q == 4'd3) begin
                ph_q <= P_RONE;
              end else begin
                rep_q <= rep_q + 4'd1;
              end
            end else begin
              mv_q <= 1'b1;
            end
          end
          P_RONE: begin
            ph_q  <= P_RA;
            rep_q <= 4'd0;
            mv_q  <= 1'b0;
          end
          P_RA: begin
            if (mv_q) begin
              mv_q <= 1'b0;
              if (rep_q == 4'd9) begin
                ph_q  <= P_RM;
                rep_q <= 4'd0;
              end else begin
                rep_q <= rep_q + 4'd1;
              end
            end else begin
              mv_q <= 1'b1;
            end
          end
          P_RM: begin
            if (mv_q) begin
              mv_q <= 1'b0;
              if (rep_q == 4'd3) begin
                ph_q <= P_IDLE;
              end else begin
                rep_q <= rep_q + 4'd1;
              end
            end else begin
              mv_q <= 1'b1;
            end
          end
          default: ph_q <= P_IDLE;
        endcase
      end

      // candidate update
      if (state_q == S_CMP && cand) begin
        found_q <= 1'b1;
        best_q  <= slot_q;
      end

      if (state_q == S_NEXT) begin
        idx_q <= idx_q - CW'(1);
      end

      // result register
      if (state_q == S_FIN && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_xfer) begin
      qx_q <= CB'(in_i.pos_x);
      qy_q <= CB'(in_i.pos_y);
      qz_q <= CB'(in_i.pos_z);
    end

    // body fields from the table read
    if (state_q == S_PAR) begin
      bx_q     <= b_rdata[0 +: CB];
      by_q     <= b_rdata[CB +: CB];
      bz_q     <= b_rdata[2*CB +: CB];
      axis_q   <= b_rdata[3*CB +: 32];
      mass_q   <= b_rdata[3*CB+32 +: 32];
      link_q   <= b_rdata[3*CB+64 +: LINK_W];
      par_ok_q <= (32'(b_parent) < MAX_BODIES);
      slot_q   <= b_raddr;
    end

    if (state_q == S_CHK) begin
      pmass_q   <= m_rdata;
      dabs_q[0] <= dx_abs;
      dabs_q[1] <= dy_abs;
      dabs_q[2] <= dz_abs;
    end

    // squared distance and left side of the radius test
    if (state_q == S_WAIT && mac_done && ph_q == P_D2MV) begin
      d_q <= x_flat[DL*32-1:0];
    end
    if (state_q == S_WAIT && mac_done && ph_q == P_LM && mv_q && rep_q == 4'd3) begin
      lhs_q <= x_flat;
    end

    if (state_q == S_CMP && cand) begin
      best_d_q <= d_q;
    end

    if (state_q == S_FIN && (!out_valid_q || out_o.ready)) begin
      out_found_q <= found_q;
      out_body_q  <= found_q ? 4'(best_q) : 4'd0;
    end
  end

endmodule

>>> rtl/snbs_checker.sv
// snbs_checker: port-level assertions for the nearest sphere-of-influence search
// depends on snbs_pkg; bound to soi_nearest_body_search
`timescale 1ns / 1ps

module snbs_checker import snbs_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_action_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_found_i,
  input logic [3:0] out_body_i
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_found_i) && $stable(out_body_i))
    else $error("result payload changed while stalled");

  // no hit reports slot zero
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_found_i |-> out_body_i == 4'd0)
    else $error("miss with nonzero slot");

  // a query occupies the block
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_action_i == ACT_QUERY |=> !in_ready_i)
    else $error("input taken during a search");

  // a table write leaves the input ready again in the next cycle
  a_write_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_action_i == ACT_WRITE |=> in_ready_i)
    else $error("write stalled the input");

endmodule

bind soi_nearest_body_search snbs_checker u_snbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_action_i (in_i.action),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_found_i (out_o.found),
  .out_body_i  (out_o.nearest_body)
);
